// File: hw/rtl/hsv_hue_saturation_adjust_unit_macros.svh
// assertion macros for the hsv hue/saturation adjust unit checker
// expects i_clk and i_rst_n in the scope where they are used
`ifndef HSV_HUE_SATURATION_ADJUST_UNIT_MACROS_SVH
`define HSV_HUE_SATURATION_ADJUST_UNIT_MACROS_SVH

// property checked outside reset
`define HSA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hsa check failed");

// property checked at every edge, reset included
`define HSA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("hsa check failed during reset");

`endif

// File: hw/rtl/hsa_pkg.sv
// shared types and constants for the hsv hue/saturation adjust unit
// no dependencies
package hsa_pkg;

    localparam int HUE_BITS   = 16;
    localparam int GAIN_BITS  = 16;
    localparam int BLEND_BITS = 17;
    localparam int SAT_BITS   = 17;

    localparam logic [16:0] TURN      = 17'd65536;
    localparam logic [15:0] HALF_TURN = 16'd32768;

    // which channel holds the maximum
    typedef enum logic [2:0] {
        MAX_RED   = 3'b001,
        MAX_GREEN = 3'b010,
        MAX_BLUE  = 3'b100
    } t_max_sel;

    typedef logic [2:0] t_sector;

    localparam t_sector SECTOR_0 = 3'd0;
    localparam t_sector SECTOR_1 = 3'd1;
    localparam t_sector SECTOR_2 = 3'd2;
    localparam t_sector SECTOR_3 = 3'd3;
    localparam t_sector SECTOR_4 = 3'd4;

endpackage

// File: hw/rtl/hsa_div.sv
// pipelined restoring divider, one quotient bit per stage
// needs i_rem < i_den; carries a tag alongside; no package use
module hsa_div #(
    parameter int DW = 19,
    parameter int QB = 16,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [QB-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [DW-1:0] r_rem [QB];
    logic [DW-1:0] r_den [QB];
    logic [QB-1:0] r_quo [QB];
    logic [TW-1:0] r_tag [QB];
    logic          r_vld [QB];

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QB-1:0] w_quo_in;
        logic [TW-1:0] w_tag_in;
        logic          w_vld_in;
        logic [DW:0]   w_sh;
        logic [DW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = i_rem;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
            assign w_tag_in = i_tag;
            assign w_vld_in = i_vld;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_tag_in = r_tag[k-1];
            assign w_vld_in = r_vld[k-1];
        end

        assign w_sh   = {w_rem_in, 1'b0};
        assign w_diff = w_sh - {1'b0, w_den_in};
        assign w_ge   = (w_sh >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
                r_den[k] <= w_den_in;
                r_quo[k] <= {w_quo_in[QB-2:0], w_ge};
                r_tag[k] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= w_vld_in;
            end
        end
    end

    assign o_vld = r_vld[QB-1];
    assign o_quo = r_quo[QB-1];
    assign o_tag = r_tag[QB-1];

endmodule

// File: hw/rtl/hsa_rgb2hsv.sv
// rgb to hexcone hsv: max/min, chroma, hue numerator, two pipelined dividers
// uses hsa_pkg and hsa_div
module hsa_rgb2hsv #(
    parameter int CB = 16,
    parameter int SW = 113
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ce,
    input  logic                         i_vld,
    input  logic [CB-1:0]                i_red,
    input  logic [CB-1:0]                i_green,
    input  logic [CB-1:0]                i_blue,
    input  logic [SW-1:0]                i_side,
    output logic                         o_vld,
    output logic [hsa_pkg::HUE_BITS-1:0] o_hue,
    output logic [hsa_pkg::SAT_BITS-1:0] o_sat,
    output logic [CB-1:0]                o_val,
    output logic [SW-1:0]                o_side
);

    localparam int DW = CB + 3;
    localparam int QB = hsa_pkg::HUE_BITS;
    localparam int TW = 1 + CB + SW;

    // stage 1: largest and smallest channel
    hsa_pkg::t_max_sel n1_sel;
    logic [CB-1:0]     n1_mx;
    logic [CB-1:0]     n1_mn;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n1_sel = hsa_pkg::MAX_RED;
            n1_mx  = i_red;
        end else if (i_green >= i_blue) begin
            n1_sel = hsa_pkg::MAX_GREEN;
            n1_mx  = i_green;
        end else begin
            n1_sel = hsa_pkg::MAX_BLUE;
            n1_mx  = i_blue;
        end
        n1_mn = i_red;
        if (i_green < n1_mn) n1_mn = i_green;
        if (i_blue < n1_mn) n1_mn = i_blue;
    end

    logic              r1_vld, r2_vld, r3_vld;
    hsa_pkg::t_max_sel r1_sel, r2_sel;
    logic [CB-1:0]     r1_mx, r1_mn, r1_r, r1_g, r1_b;
    logic [SW-1:0]     r1_side, r2_side, r3_side;
    logic [CB-1:0]     r2_mx, r2_c, r2_r, r2_g, r2_b;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_sel  <= n1_sel;
            r1_mx   <= n1_mx;
            r1_mn   <= n1_mn;
            r1_r    <= i_red;
            r1_g    <= i_green;
            r1_b    <= i_blue;
            r1_side <= i_side;
            // stage 2: chroma
            r2_sel  <= r1_sel;
            r2_mx   <= r1_mx;
            r2_c    <= r1_mx - r1_mn;
            r2_r    <= r1_r;
            r2_g    <= r1_g;
            r2_b    <= r1_b;
            r2_side <= r1_side;
        end
    end

    // stage 3: hue numerator in sixths, divisors and first saturation bit
    logic [DW-1:0] w_c;
    logic [DW-1:0] w_c6;
    logic [DW-1:0] n3_num;
    logic          n3_q16;
    logic          n3_gray;

    assign w_c  = DW'(r2_c);
    assign w_c6 = (w_c << 2) + (w_c << 1);

    always_comb begin
        case (r2_sel)
            hsa_pkg::MAX_RED: begin
                if (r2_g >= r2_b) begin
                    n3_num = DW'(r2_g - r2_b);
                end else begin
                    n3_num = w_c6 - DW'(r2_b - r2_g);
                end
            end
            hsa_pkg::MAX_GREEN: n3_num = (w_c << 1) + DW'(r2_b) - DW'(r2_r);
            hsa_pkg::MAX_BLUE:  n3_num = (w_c << 2) + DW'(r2_r) - DW'(r2_g);
            default:            n3_num = '0;
        endcase
    end

    assign n3_gray = (r2_c == '0);
    assign n3_q16  = !n3_gray && (r2_c == r2_mx);

    logic [DW-1:0] r3_num, r3_den;
    logic [CB-1:0] r3_srem, r3_mx;
    logic          r3_q16, r3_gray;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r3_num  <= n3_num;
            r3_den  <= w_c6;
            r3_srem <= n3_q16 ? '0 : r2_c;
            r3_mx   <= r2_mx;
            r3_q16  <= n3_q16;
            r3_gray <= n3_gray;
            r3_side <= r2_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // dividers
    logic          w_hdiv_vld, w_sdiv_vld;
    logic [QB-1:0] w_hquo, w_squo;
    logic [TW-1:0] w_htag;
    logic          w_stag;

    hsa_div #(.DW(DW), .QB(QB), .TW(TW)) u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (i_ce),
        .i_vld   (r3_vld),
        .i_rem   (r3_num),
        .i_den   (r3_den),
        .i_tag   ({r3_gray, r3_mx, r3_side}),
        .o_vld   (w_hdiv_vld),
        .o_quo   (w_hquo),
        .o_tag   (w_htag)
    );

    hsa_div #(.DW(CB), .QB(QB), .TW(1)) u_sat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (i_ce),
        .i_vld   (r3_vld),
        .i_rem   (r3_srem),
        .i_den   (r3_mx),
        .i_tag   (r3_q16),
        .o_vld   (w_sdiv_vld),
        .o_quo   (w_squo),
        .o_tag   (w_stag)
    );

    logic w_gray;
    assign w_gray = w_htag[TW-1];

    logic r4_vld;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_hue  <= w_gray ? '0 : w_hquo;
            o_sat  <= w_gray ? '0 : {w_stag, w_squo};
            o_val  <= w_htag[SW +: CB];
            o_side <= w_htag[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_ce) begin
            r4_vld <= w_hdiv_vld & w_sdiv_vld;
        end
    end

    assign o_vld = r4_vld;

endmodule

// File: hw/rtl/hsa_adjust.sv
// hue shift, saturation and value gains, hexcone hsv back to rgb
// uses hsa_pkg
module hsa_adjust #(
    parameter int CB = 16,
    parameter int FB = 12,
    parameter int SW = 65
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_vld,
    input  logic [hsa_pkg::HUE_BITS-1:0]  i_hue,
    input  logic [hsa_pkg::SAT_BITS-1:0]  i_sat,
    input  logic [CB-1:0]                 i_val,
    input  logic [hsa_pkg::HUE_BITS-1:0]  i_hs,
    input  logic [hsa_pkg::GAIN_BITS-1:0] i_sg,
    input  logic [hsa_pkg::GAIN_BITS-1:0] i_vg,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_vld,
    output logic [CB-1:0]                 o_red,
    output logic [CB-1:0]                 o_green,
    output logic [CB-1:0]                 o_blue,
    output logic [SW-1:0]                 o_side
);

    localparam int SMW = hsa_pkg::SAT_BITS + hsa_pkg::GAIN_BITS;
    localparam int VMW = CB + hsa_pkg::GAIN_BITS;
    localparam logic [CB-1:0] CHMAX = {CB{1'b1}};

    logic [4:0]    r_vld;
    logic [SW-1:0] r_side [5];

    // stage 1: hue shift and gain products
    logic [15:0]     r1_hue;
    logic [SMW-1:0]  r1_satm;
    logic [VMW-1:0]  r1_valm;

    // stage 2: clamps and sector
    logic [SMW-1:0]  w_sat_sh;
    logic [VMW-1:0]  w_val_sh;
    logic [18:0]     w_h6;
    logic [16:0]     r2_s;
    logic [CB-1:0]   r2_v;
    hsa_pkg::t_sector r2_sec;
    logic [15:0]     r2_f;

    assign w_sat_sh = r1_satm >> FB;
    assign w_val_sh = r1_valm >> FB;
    assign w_h6     = ({3'b0, r1_hue} << 2) + ({3'b0, r1_hue} << 1);

    // stage 3: products with saturation
    logic [CB+16:0]   r3_vs;
    logic [32:0]      r3_sf;
    logic [33:0]      r3_sfc;
    logic [CB-1:0]    r3_v;
    hsa_pkg::t_sector r3_sec;

    // stage 4: p and value products
    logic [CB-1:0]    r4_p, r4_v;
    logic [CB+15:0]   r4_vq;
    logic [CB+16:0]   r4_vt;
    hsa_pkg::t_sector r4_sec;

    logic [CB-1:0] w_q, w_t;
    assign w_q = r4_v - r4_vq[CB+15:16];
    assign w_t = r4_v - r4_vt[CB+15:16];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_hue  <= i_hue + i_hs + hsa_pkg::HALF_TURN;
            r1_satm <= SMW'(i_sat) * SMW'(i_sg);
            r1_valm <= VMW'(i_val) * VMW'(i_vg);

            r2_s    <= (w_sat_sh > SMW'(hsa_pkg::TURN)) ? hsa_pkg::TURN : w_sat_sh[16:0];
            r2_v    <= (w_val_sh > VMW'(CHMAX)) ? CHMAX : w_val_sh[CB-1:0];
            r2_sec  <= w_h6[18:16];
            r2_f    <= w_h6[15:0];

            r3_vs   <= (CB+17)'(r2_v) * (CB+17)'(r2_s);
            r3_sf   <= 33'(r2_s) * 33'(r2_f);
            r3_sfc  <= 34'(r2_s) * 34'(hsa_pkg::TURN - {1'b0, r2_f});
            r3_v    <= r2_v;
            r3_sec  <= r2_sec;

            r4_p    <= r3_v - r3_vs[CB+15:16];
            r4_vq   <= (CB+16)'(r3_v) * (CB+16)'(r3_sf[31:16]);
            r4_vt   <= (CB+17)'(r3_v) * (CB+17)'(r3_sfc[32:16]);
            r4_v    <= r3_v;
            r4_sec  <= r3_sec;

            // stage 5: sector select
            case (r4_sec)
                hsa_pkg::SECTOR_0: begin
                    o_red <= r4_v;  o_green <= w_t;   o_blue <= r4_p;
                end
                hsa_pkg::SECTOR_1: begin
                    o_red <= w_q;   o_green <= r4_v;  o_blue <= r4_p;
                end
                hsa_pkg::SECTOR_2: begin
                    o_red <= r4_p;  o_green <= r4_v;  o_blue <= w_t;
                end
                hsa_pkg::SECTOR_3: begin
                    o_red <= r4_p;  o_green <= w_q;   o_blue <= r4_v;
                end
                hsa_pkg::SECTOR_4: begin
                    o_red <= w_t;   o_green <= r4_p;  o_blue <= r4_v;
                end
                default: begin
                    o_red <= r4_v;  o_green <= r4_p;  o_blue <= w_q;
                end
            endcase

            r_side[0] <= i_side;
            for (int k = 1; k < 5; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    assign o_vld  = r_vld[4];
    assign o_side = r_side[4];

endmodule

// File: hw/rtl/hsa_blend.sv
// blend of adjusted and original color, output register
// uses hsa_pkg
module hsa_blend #(
    parameter int CB = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ce,
    input  logic                           i_vld,
    input  logic [CB-1:0]                  i_red,
    input  logic [CB-1:0]                  i_green,
    input  logic [CB-1:0]                  i_blue,
    input  logic [CB-1:0]                  i_orig_red,
    input  logic [CB-1:0]                  i_orig_green,
    input  logic [CB-1:0]                  i_orig_blue,
    input  logic [hsa_pkg::BLEND_BITS-1:0] i_fa,
    output logic                           o_vld,
    output logic [CB-1:0]                  o_red,
    output logic [CB-1:0]                  o_green,
    output logic [CB-1:0]                  o_blue
);

    localparam int PW = CB + 17;

    logic [16:0]   w_fa, w_wo;
    logic [PW-1:0] r1_mo [3];
    logic [PW-1:0] r1_mr [3];
    logic [PW:0]   w_sum [3];
    logic [1:0]    r_vld;

    assign w_fa = (i_fa > hsa_pkg::TURN) ? hsa_pkg::TURN : i_fa;
    assign w_wo = hsa_pkg::TURN - w_fa;

    for (genvar k = 0; k < 3; k++) begin : g_sum
        assign w_sum[k] = {1'b0, r1_mo[k]} + {1'b0, r1_mr[k]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_mo[0] <= PW'(i_orig_red)   * PW'(w_wo);
            r1_mo[1] <= PW'(i_orig_green) * PW'(w_wo);
            r1_mo[2] <= PW'(i_orig_blue)  * PW'(w_wo);
            r1_mr[0] <= PW'(i_red)   * PW'(w_fa);
            r1_mr[1] <= PW'(i_green) * PW'(w_fa);
            r1_mr[2] <= PW'(i_blue)  * PW'(w_fa);
            o_red    <= w_sum[0][CB+15:16];
            o_green  <= w_sum[1][CB+15:16];
            o_blue   <= w_sum[2][CB+15:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    assign o_vld = r_vld[1];

endmodule

// File: hw/rtl/hsv_hue_saturation_adjust_unit.sv
// hsv hue/saturation/value adjust with blend, top level
// uses hsa_pkg, hsa_rgb2hsv, hsa_adjust, hsa_blend
//
// usage:
// - one pixel item per beat on the slave stream: rgb plus hue shift,
//   saturation and value gains in unsigned q4.12, and blend factor
// - one adjusted pixel item per beat on the master stream
// - fully pipelined: unless the output stalls, an item can enter every
//   cycle and one result leaves per cycle; the stages in order are 3 front
//   stages, 16 divider stages (one quotient bit each for hue and
//   saturation), 1 hsv register, 5 adjust stages, 2 blend stages
// - the whole pipeline advances on one enable; it moves whenever the
//   output register is empty or being taken, so s_axis_tready is high
//   unless a finished result sits unaccepted in the output register
// - while the receiver stalls, every stage holds its item and valid bit;
//   nothing is dropped or repeated, and the pipeline refills on release
// - synchronous active low reset clears only the valid bits; data
//   registers keep whatever they held
// - gray pixels give hue 0 and saturation 0; saturation after gain clamps
//   to one, value after gain saturates to the channel maximum
// - blend factor above one turn counts as one
module hsv_hue_saturation_adjust_unit #(
    parameter int CHANNEL_BITS  = 16,
    parameter int FRACTION_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // orig_red, orig_green, orig_blue, hue_shift, saturation_gain,
    // value_gain, blend_factor, zero pad (lowest bit up)
    input  logic [((3*CHANNEL_BITS+65+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // out_red, out_green, out_blue, zero pad (lowest bit up)
    output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]   o_m_axis_tdata
);

    localparam int CB    = CHANNEL_BITS;
    localparam int OUT_W = ((3*CB+7)/8)*8;
    localparam int SW1   = 3*CB + 65;   // everything but the hsv result
    localparam int SW2   = 3*CB + 17;   // original color and blend factor

    logic w_ce;
    logic w_in_vld;

    // pipeline moves unless the output register holds a result not taken
    assign w_ce            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_ce;
    assign w_in_vld        = i_s_axis_tvalid;

    // input fields
    logic [CB-1:0]  w_r, w_g, w_b;
    logic [SW1-1:0] w_side1;

    assign w_r     = i_s_axis_tdata[CB-1:0];
    assign w_g     = i_s_axis_tdata[2*CB-1:CB];
    assign w_b     = i_s_axis_tdata[3*CB-1:2*CB];
    assign w_side1 = i_s_axis_tdata[SW1-1:0];

    // rgb to hsv
    logic                         w_hsv_vld;
    logic [hsa_pkg::HUE_BITS-1:0] w_hue;
    logic [hsa_pkg::SAT_BITS-1:0] w_sat;
    logic [CB-1:0]                w_val;
    logic [SW1-1:0]               w_side1_d;

    hsa_rgb2hsv #(.CB(CB), .SW(SW1)) u_rgb2hsv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_vld   (w_in_vld),
        .i_red   (w_r),
        .i_green (w_g),
        .i_blue  (w_b),
        .i_side  (w_side1),
        .o_vld   (w_hsv_vld),
        .o_hue   (w_hue),
        .o_sat   (w_sat),
        .o_val   (w_val),
        .o_side  (w_side1_d)
    );

    logic [SW2-1:0] w_side2, w_side2_d;
    assign w_side2 = {w_side1_d[3*CB+64:3*CB+48], w_side1_d[3*CB-1:0]};

    // adjust and back to rgb
    logic          w_adj_vld;
    logic [CB-1:0] w_ar, w_ag, w_ab;

    hsa_adjust #(.CB(CB), .FB(FRACTION_BITS), .SW(SW2)) u_adjust (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_vld   (w_hsv_vld),
        .i_hue   (w_hue),
        .i_sat   (w_sat),
        .i_val   (w_val),
        .i_hs    (w_side1_d[3*CB+15:3*CB]),
        .i_sg    (w_side1_d[3*CB+31:3*CB+16]),
        .i_vg    (w_side1_d[3*CB+47:3*CB+32]),
        .i_side  (w_side2),
        .o_vld   (w_adj_vld),
        .o_red   (w_ar),
        .o_green (w_ag),
        .o_blue  (w_ab),
        .o_side  (w_side2_d)
    );

    // blend and output register
    logic [CB-1:0] w_or, w_og, w_ob;

    hsa_blend #(.CB(CB)) u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ce         (w_ce),
        .i_vld        (w_adj_vld),
        .i_red        (w_ar),
        .i_green      (w_ag),
        .i_blue       (w_ab),
        .i_orig_red   (w_side2_d[CB-1:0]),
        .i_orig_green (w_side2_d[2*CB-1:CB]),
        .i_orig_blue  (w_side2_d[3*CB-1:2*CB]),
        .i_fa         (w_side2_d[3*CB+16:3*CB]),
        .o_vld        (o_m_axis_tvalid),
        .o_red        (w_or),
        .o_green      (w_og),
        .o_blue       (w_ob)
    );

    assign o_m_axis_tdata = OUT_W'({w_ob, w_og, w_or});

endmodule

// File: hw/rtl/hsa_checker.sv
// port-level checker for the hsv hue/saturation adjust unit, with bind
// uses hsv_hue_saturation_adjust_unit_macros.svh
`include "hsv_hue_saturation_adjust_unit_macros.svh"

module hsa_checker #(
    parameter int OUT_W = 48
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    // a stalled result stays and keeps its value
    `HSA_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // input side is ready exactly when the output register can move
    `HSA_ASSERT(a_ready_link, 1'b1 |-> (o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready)))

    // reset empties the pipeline
    `HSA_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind hsv_hue_saturation_adjust_unit hsa_checker #(
    .OUT_W(((3*CHANNEL_BITS+7)/8)*8)
) u_hsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
